// File: rtl/dlpr_pkg.sv
// Shared types, constants and helpers for the daily light profile ramp.
package dlpr_pkg;

  localparam int unsigned MAX_ENTRIES = 32;
  localparam int unsigned SEC_W     = 17;
  localparam int unsigned MS_W      = 10;
  localparam int unsigned LVL_W     = 7;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned PWM_W     = 16;
  localparam int unsigned STEP_W    = 12;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned ENT_W     = SEC_W + LVL_W;
  localparam int unsigned TS_W      = 20;  // signed seconds, spans -1 day .. 2.5 days
  localparam int unsigned D_W       = 29;  // span in ms
  localparam int unsigned E_W       = 31;  // signed elapsed ms
  localparam int unsigned P_W       = 36;  // level * span
  localparam int unsigned P2_W      = 39;
  localparam int unsigned NUM_W     = 40;
  localparam int unsigned HALF_W    = 18;  // num split for the scale multiply
  localparam int unsigned PROD_W    = 52;
  localparam int unsigned QUOT_W    = 16;
  localparam int unsigned KCNT_W    = 5;

  localparam logic [SEC_W-1:0] DAY_SECS = SEC_W'(86400);
  localparam logic [LVL_W-1:0] PCT_MAX  = LVL_W'(100);

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_ADD    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_TEST   = 2'd3
  } dlpr_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_SCALE = 4'd0,
    REG_SLEW_STEP  = 4'd1
  } dlpr_reg_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_AS_RD, S_AS_CHK, S_SH, S_SH_WR, S_RM, S_RM_WR,
    S_TK_L2, S_TK_RD, S_TK_CHK, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
    S_DIVPRE, S_DIV, S_SLEW, S_FIN
  } dlpr_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_ADD_CHK, OP_ADD_END, OP_SHIFT_UP, OP_PUT,
    OP_SHIFT_DN, OP_REM_DONE, OP_TEST_START, OP_EMPTY, OP_TEST_GOAL,
    OP_SAVE_LAST, OP_WRAP, OP_TK_CHK, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5,
    OP_M6, OP_DIV_INIT, OP_DIV_STEP, OP_SLEW, OP_OUT
  } dlpr_op_e;

  typedef enum logic [1:0] {
    RD_IDX, RD_IDX_M1, RD_IDX_P1, RD_LAST
  } dlpr_rd_e;

  typedef struct packed {
    dlpr_op_e op;
    logic     rd_en;
    dlpr_rd_e rd_src;
    logic     in_ready;
  } dlpr_cmd_t;

  typedef struct packed {
    dlpr_func_e func;
    logic       ok;
    logic       cnt_zero;
    logic       single;
    logic       test_on;
    logic       idx_at_cnt;
    logic       idx_at_pos;
    logic       idx_last;
    logic       hit;
    logic       div_done;
    logic       out_free;
  } dlpr_sts_t;

  function automatic logic [LVL_W-1:0] sat_pct(input logic [LVL_W-1:0] p);
    return (p > PCT_MAX) ? PCT_MAX : p;
  endfunction

  function automatic logic [SEC_W-1:0] day_key(input logic [SEC_W-1:0] t);
    return (t >= DAY_SECS) ? t - DAY_SECS : t;
  endfunction

endpackage

// File: rtl/dlpr_if.sv
// Valid/ready channel interfaces for items and results.
interface dlpr_in_if import dlpr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [SEC_W-1:0] sec_of_day;
  logic [MS_W-1:0]  milli_of_sec;
  logic [SEC_W-1:0] new_time;
  logic [LVL_W-1:0] new_level;
  logic [POS_W-1:0] remove_pos;
  logic [LVL_W-1:0] test_level;

  modport source (output valid, func, sec_of_day, milli_of_sec, new_time, new_level,
                  remove_pos, test_level, input ready);
  modport sink (input valid, func, sec_of_day, milli_of_sec, new_time, new_level,
                remove_pos, test_level, output ready);
endinterface

interface dlpr_out_if import dlpr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PWM_W-1:0]     pwm_out;
  logic                 write_needed;
  logic [PWM_W-1:0]     goal_level;
  logic                 op_ok;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, pwm_out, write_needed, goal_level, op_ok, entry_count,
                  input ready);
  modport sink (input valid, pwm_out, write_needed, goal_level, op_ok, entry_count,
                output ready);
endinterface

// File: rtl/dlpr_ctrl.sv
// Sequencer for table edits, target search, interpolation and slew.
module dlpr_ctrl import dlpr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  dlpr_sts_t sts_i,
  output dlpr_cmd_t cmd_o
);

  dlpr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = OP_NONE;
    cmd_o.rd_en     = 1'b0;
    cmd_o.rd_src    = RD_IDX;
    cmd_o.in_ready  = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.func)
          FN_TICK: begin
            if (sts_i.cnt_zero) begin
              cmd_o.op = OP_EMPTY;
              state_d  = S_FIN;
            end else if (sts_i.test_on) begin
              cmd_o.op = OP_TEST_GOAL;
              state_d  = S_M5;
            end else begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_src = RD_LAST;
              state_d      = S_TK_L2;
            end
          end
          FN_ADD:    state_d = sts_i.ok ? S_AS_RD : S_FIN;
          FN_REMOVE: state_d = sts_i.ok ? S_RM : S_FIN;
          FN_TEST: begin
            cmd_o.op = OP_TEST_START;
            state_d  = S_FIN;
          end
          default: state_d = S_FIN;
        endcase
      end
      // insertion: find position, then move the tail up one entry at a time
      S_AS_RD: begin
        if (sts_i.idx_at_cnt) begin
          cmd_o.op = OP_ADD_END;
          state_d  = S_SH;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_AS_CHK;
        end
      end
      S_AS_CHK: begin
        cmd_o.op = OP_ADD_CHK;
        state_d  = sts_i.hit ? S_SH : S_AS_RD;
      end
      S_SH: begin
        if (sts_i.idx_at_pos) begin
          cmd_o.op = OP_PUT;
          state_d  = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_IDX_M1;
          state_d      = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd_o.op = OP_SHIFT_UP;
        state_d  = S_SH;
      end
      S_RM: begin
        if (sts_i.idx_last) begin
          cmd_o.op = OP_REM_DONE;
          state_d  = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_src = RD_IDX_P1;
          state_d      = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd_o.op = OP_SHIFT_DN;
        state_d  = S_RM;
      end
      S_TK_L2: begin
        cmd_o.op = OP_SAVE_LAST;
        state_d  = sts_i.single ? S_M1 : S_TK_RD;
      end
      S_TK_RD: begin
        if (sts_i.idx_at_cnt) begin
          cmd_o.op = OP_WRAP;
          state_d  = S_M1;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_TK_CHK;
        end
      end
      S_TK_CHK: begin
        cmd_o.op = OP_TK_CHK;
        state_d  = sts_i.hit ? S_M1 : S_TK_RD;
      end
      S_M1: begin
        cmd_o.op = OP_M1;
        state_d  = S_M2;
      end
      S_M2: begin
        cmd_o.op = OP_M2;
        state_d  = S_M3;
      end
      S_M3: begin
        cmd_o.op = OP_M3;
        state_d  = S_M4;
      end
      S_M4: begin
        cmd_o.op = OP_M4;
        state_d  = S_M5;
      end
      S_M5: begin
        cmd_o.op = OP_M5;
        state_d  = S_M6;
      end
      S_M6: begin
        cmd_o.op = OP_M6;
        state_d  = S_DIVPRE;
      end
      S_DIVPRE: begin
        cmd_o.op = OP_DIV_INIT;
        state_d  = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_SLEW;
        end else begin
          cmd_o.op = OP_DIV_STEP;
        end
      end
      S_SLEW: begin
        cmd_o.op = OP_SLEW;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: rtl/dlpr_dp.sv
// Datapath: target table memory, interpolation arithmetic, divider, slew, result register.
module dlpr_dp import dlpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dlpr_cmd_t            cmd_i,
  output dlpr_sts_t            sts_o,
  input  logic [1:0]           func_i,
  input  logic [SEC_W-1:0]     sec_of_day_i,
  input  logic [MS_W-1:0]      milli_of_sec_i,
  input  logic [SEC_W-1:0]     new_time_i,
  input  logic [LVL_W-1:0]     new_level_i,
  input  logic [POS_W-1:0]     remove_pos_i,
  input  logic [LVL_W-1:0]     test_level_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [PWM_W-1:0]     pwm_out_o,
  output logic                 write_needed_o,
  output logic [PWM_W-1:0]     goal_level_o,
  output logic                 op_ok_o,
  output logic [CNT_OUT_W-1:0] entry_count_o
);

  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  // table memory
  logic [ENT_W-1:0] mem_q [MAX_ENTRIES];
  logic [ENT_W-1:0] rd_q;
  logic [CW-1:0]    raddr;
  logic             we;
  logic [CW-1:0]    waddr;
  logic [ENT_W-1:0] wdata;

  // control state
  logic [CW-1:0]     cnt_q, idx_q, pos_q;
  logic [PWM_W-1:0]  drive_q, goal_q, fs_q;
  logic [STEP_W-1:0] step_q;
  logic              test_on_q;
  logic [LVL_W-1:0]  test_pct_q;
  logic [SEC_W-1:0]  test_start_q;
  logic              out_valid_q;

  // item and working registers
  dlpr_func_e        func_q;
  logic [SEC_W-1:0]  sec_q, new_time_q;
  logic [MS_W-1:0]   milli_q;
  logic [LVL_W-1:0]  new_level_q, test_level_q;
  logic              ok_q, wr_q;
  logic [SEC_W-1:0]  last_t_q, first_t_q, prev_t_q;
  logic [LVL_W-1:0]  last_l_q, first_l_q, prev_l_q;
  logic signed [TS_W-1:0] lt_q, ct_q, dt_q, el_q;
  logic [LVL_W-1:0]  lv_q, cv_q;
  logic signed [LVL_W:0] dv_q;
  logic              dtle0_q;
  logic [D_W-1:0]    d_q;
  logic signed [E_W-1:0]  e_q;
  logic [P_W-1:0]    p1_q, cvd_q, dd_q;
  logic signed [P2_W-1:0] p2_q;
  logic signed [NUM_W-1:0] num_q;
  logic              numpos_q;
  logic [2*HALF_W-2:0] plo_q, phi_q;
  logic [PROD_W-1:0] prod_q, rem_q;
  logic [PROD_W-2:0] dsh_q;
  logic [QUOT_W-1:0] quot_q;
  logic [KCNT_W-1:0] kcnt_q;
  logic              sat_q;
  logic [PWM_W-1:0]  res_pwm_q, res_goal_q;
  logic              res_wr_q, res_ok_q;
  logic [CW-1:0]     res_cnt_q;

  logic [SEC_W-1:0] rd_t;
  logic [LVL_W-1:0] rd_l;
  logic             hit;
  logic signed [TS_W-1:0] lt_hit;
  logic [CMPW-1:0]  rpos_w;
  logic             full, rpos_bad;

  assign rd_t = rd_q[ENT_W-1:LVL_W];
  assign rd_l = rd_q[LVL_W-1:0];
  assign full = (cnt_q == CW'(MAX_ENTRIES));
  assign rpos_w   = CMPW'(remove_pos_i);
  assign rpos_bad = (rpos_w >= CMPW'(cnt_q));

  always_comb begin
    if (func_q == FN_TICK) begin
      hit = (rd_t > sec_q);
    end else begin
      hit = (day_key(new_time_q) < day_key(rd_t));
    end
  end

  always_comb begin
    if (idx_q == '0) begin
      lt_hit = $signed({{(TS_W-SEC_W){1'b0}}, last_t_q}) - $signed(TS_W'(DAY_SECS));
    end else begin
      lt_hit = $signed({{(TS_W-SEC_W){1'b0}}, prev_t_q});
    end
  end

  // memory ports
  always_comb begin
    case (cmd_i.rd_src)
      RD_IDX:    raddr = idx_q;
      RD_IDX_M1: raddr = idx_q - CW'(1);
      RD_IDX_P1: raddr = idx_q + CW'(1);
      RD_LAST:   raddr = cnt_q - CW'(1);
      default:   raddr = idx_q;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = rd_q;
    case (cmd_i.op)
      OP_SHIFT_UP, OP_SHIFT_DN: we = 1'b1;
      OP_PUT: begin
        we    = 1'b1;
        waddr = pos_q;
        wdata = {new_time_q, sat_pct(new_level_q)};
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[raddr[AW-1:0]];
    end
  end

  // interpolation combinational pieces
  logic signed [NUM_W-1:0] sum, cvd_s, num_n;
  always_comb begin
    sum   = $signed({{(NUM_W-P_W){1'b0}}, p1_q}) + NUM_W'(p2_q);
    cvd_s = $signed({{(NUM_W-P_W){1'b0}}, cvd_q});
    num_n = sum;
    if (dv_q > 0) begin
      if (sum > cvd_s) num_n = cvd_s;
    end else begin
      if (sum < cvd_s) num_n = cvd_s;
    end
  end

  logic [PROD_W-1:0] dsh_full;
  logic              div_ge;
  assign dsh_full = {1'b0, dsh_q};
  assign div_ge   = (rem_q >= dsh_full);

  // slew toward the new goal
  logic [PWM_W-1:0] goal_n, drive_n, upv, dnv;
  logic [PWM_W:0]   up1;
  logic [PWM_W+1:0] up2;
  logic signed [PWM_W+2:0] dn1, dn2, goal_s;
  logic signed [SEC_W+1:0] now_s, st_s;
  logic test_end;

  always_comb begin
    // a zero or negative numerator gives zero before any saturation
    goal_n = !numpos_q ? '0 : (sat_q ? {PWM_W{1'b1}} : quot_q);
    up1 = {1'b0, drive_q} + (PWM_W+1)'(step_q);
    up2 = {1'b0, up1};
    if ({2'b0, goal_n} > ({1'b0, up1} + (PWM_W+2)'(100))) begin
      up2 = {1'b0, up1} + (PWM_W+2)'(step_q);
    end
    upv = (up2 > {2'b0, goal_n}) ? goal_n : up2[PWM_W-1:0];
    goal_s = $signed({3'b0, goal_n});
    dn1 = $signed({3'b0, drive_q}) - $signed((PWM_W+3)'(step_q));
    dn2 = dn1;
    if (goal_s < dn1 - 19'sd100) begin
      dn2 = dn1 - $signed((PWM_W+3)'(step_q));
    end
    dnv = (dn2 < goal_s) ? goal_n : dn2[PWM_W-1:0];
    if (goal_n == drive_q) begin
      drive_n = drive_q;
    end else if (goal_n > drive_q) begin
      drive_n = upv;
    end else begin
      drive_n = dnv;
    end
    now_s = $signed({2'b0, sec_q});
    st_s  = $signed({2'b0, test_start_q});
    test_end = (st_s < now_s - 19'sd60) || (st_s > now_s);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      drive_q      <= '0;
      goal_q       <= '0;
      test_on_q    <= 1'b0;
      test_pct_q   <= '0;
      test_start_q <= '0;
      fs_q         <= PWM_W'(4095);
      step_q       <= STEP_W'(1);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (dlpr_reg_e'(cfg_idx_i))
          REG_FULL_SCALE: fs_q   <= cfg_data_i[PWM_W-1:0];
          REG_SLEW_STEP:  step_q <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_PUT:      cnt_q <= cnt_q + CW'(1);
        OP_REM_DONE: cnt_q <= cnt_q - CW'(1);
        OP_TEST_START: begin
          test_on_q    <= 1'b1;
          test_pct_q   <= sat_pct(test_level_q);
          test_start_q <= sec_q;
        end
        OP_EMPTY: begin
          drive_q <= '0;
          goal_q  <= '0;
        end
        OP_SLEW: begin
          goal_q  <= goal_n;
          drive_q <= drive_n;
          if (test_on_q && test_end) test_on_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // item latch and working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LATCH: begin
        func_q       <= dlpr_func_e'(func_i);
        sec_q        <= sec_of_day_i;
        milli_q      <= milli_of_sec_i;
        new_time_q   <= new_time_i;
        new_level_q  <= new_level_i;
        test_level_q <= test_level_i;
        wr_q         <= 1'b0;
        ok_q         <= !(((func_i == FN_ADD) && full) ||
                          ((func_i == FN_REMOVE) && rpos_bad));
        idx_q        <= (func_i == FN_REMOVE) ? rpos_w[CW-1:0] : '0;
      end
      OP_ADD_CHK: begin
        if (hit) begin
          pos_q <= idx_q;
          idx_q <= cnt_q;
        end else begin
          idx_q <= idx_q + CW'(1);
        end
      end
      OP_ADD_END:  pos_q <= idx_q;
      OP_SHIFT_UP: idx_q <= idx_q - CW'(1);
      OP_SHIFT_DN: idx_q <= idx_q + CW'(1);
      OP_EMPTY:    wr_q  <= (drive_q != '0);
      OP_TEST_GOAL: begin
        num_q <= NUM_W'(test_pct_q);
        dd_q  <= P_W'(100);
      end
      OP_SAVE_LAST: begin
        last_t_q <= rd_t;
        last_l_q <= rd_l;
        idx_q    <= '0;
        // single target: constant level across the whole day
        lt_q <= '0;
        ct_q <= $signed(TS_W'(DAY_SECS));
        lv_q <= rd_l;
        cv_q <= rd_l;
      end
      OP_WRAP: begin
        ct_q <= $signed({{(TS_W-SEC_W){1'b0}}, first_t_q}) + $signed(TS_W'(DAY_SECS));
        cv_q <= first_l_q;
        lt_q <= $signed({{(TS_W-SEC_W){1'b0}}, last_t_q});
        lv_q <= last_l_q;
      end
      OP_TK_CHK: begin
        if (idx_q == '0) begin
          first_t_q <= rd_t;
          first_l_q <= rd_l;
        end
        if (hit) begin
          ct_q <= $signed({{(TS_W-SEC_W){1'b0}}, rd_t});
          cv_q <= rd_l;
          lt_q <= lt_hit;
          lv_q <= (idx_q == '0) ? last_l_q : prev_l_q;
        end else begin
          prev_t_q <= rd_t;
          prev_l_q <= rd_l;
          idx_q    <= idx_q + CW'(1);
        end
      end
      OP_M1: begin
        dt_q <= ct_q - lt_q;
        el_q <= $signed({{(TS_W-SEC_W){1'b0}}, sec_q}) - lt_q;
        dv_q <= $signed({1'b0, cv_q}) - $signed({1'b0, lv_q});
      end
      OP_M2: begin
        dtle0_q <= (dt_q <= 0);
        d_q     <= D_W'(dt_q[TS_W-2:0] * 10'd1000);
        e_q     <= E_W'(el_q * 11'sd1000) + $signed({{(E_W-MS_W){1'b0}}, milli_q});
      end
      OP_M3: begin
        p1_q  <= P_W'(lv_q * d_q);
        cvd_q <= P_W'(cv_q * d_q);
        dd_q  <= P_W'(d_q * 7'd100);
        p2_q  <= P2_W'(dv_q * e_q);
      end
      OP_M4: begin
        if (dtle0_q) begin
          num_q <= NUM_W'(cv_q);
          dd_q  <= P_W'(100);
        end else begin
          num_q <= num_n;
        end
      end
      OP_M5: begin
        numpos_q <= (num_q > 0);
        plo_q    <= fs_q * num_q[HALF_W-1:0];
        phi_q    <= fs_q * num_q[2*HALF_W-1:HALF_W];
      end
      OP_M6: begin
        prod_q <= PROD_W'(plo_q) + PROD_W'({phi_q, {HALF_W{1'b0}}});
      end
      OP_DIV_INIT: begin
        sat_q  <= (prod_q >= {dd_q, {QUOT_W{1'b0}}});
        rem_q  <= prod_q;
        dsh_q  <= {dd_q, {(QUOT_W-1){1'b0}}};
        quot_q <= '0;
        kcnt_q <= KCNT_W'(QUOT_W);
      end
      OP_DIV_STEP: begin
        if (div_ge) rem_q <= rem_q - dsh_full;
        quot_q <= {quot_q[QUOT_W-2:0], div_ge};
        dsh_q  <= dsh_q >> 1;
        kcnt_q <= kcnt_q - KCNT_W'(1);
      end
      OP_SLEW: wr_q <= (goal_n != drive_q);
      OP_OUT: begin
        res_pwm_q  <= drive_q;
        res_goal_q <= goal_q;
        res_wr_q   <= wr_q;
        res_ok_q   <= ok_q;
        res_cnt_q  <= cnt_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.func       = func_q;
    sts_o.ok         = ok_q;
    sts_o.cnt_zero   = (cnt_q == '0);
    sts_o.single     = (cnt_q == CW'(1));
    sts_o.test_on    = test_on_q;
    sts_o.idx_at_cnt = (idx_q == cnt_q);
    sts_o.idx_at_pos = (idx_q == pos_q);
    sts_o.idx_last   = (({1'b0, idx_q} + (CW+1)'(1)) == {1'b0, cnt_q});
    sts_o.hit        = hit;
    sts_o.div_done   = (kcnt_q == '0);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign pwm_out_o      = res_pwm_q;
  assign write_needed_o = res_wr_q;
  assign goal_level_o   = res_goal_q;
  assign op_ok_o        = res_ok_q;
  assign entry_count_o  = CNT_OUT_W'(res_cnt_q);

endmodule

// File: rtl/daily_light_profile_ramp.sv
// Daily light profile ramp: top level joining the sequencer and the datapath.
//
// One item enters on in_i (valid/ready); each item gives exactly one result
// on out_o (valid/ready). Configuration (full scale, slew step) is written
// through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so only while
// the block is idle, which the block itself does not enforce. Items are
// handled one at a time; ready is high only between items.
// The time per item is set by the table sequencer, which reads one entry at
// a time, and by the shift-subtract divider:
//   add:    scan to the slot, then move the tail up
//   remove: move the entries after pos down
//   tick:   scan to the target, interpolate, divide and slew; test mode
//           skips the scan and steps M1 to M4; an empty table ends at once
//   test start: latch the test level and the start time
// The result sits in an output register; while the receiver stalls, the
// next item is still taken and worked on up to its own result.
// Reset empties the table, zeroes the drive level and goal, leaves test mode off
// and loads full scale 4095 and slew step 1. The table needs no clearing.
module daily_light_profile_ramp import dlpr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  dlpr_in_if.sink              in_i,
  dlpr_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  dlpr_cmd_t cmd;
  dlpr_sts_t sts;

  assign in_i.ready = cmd.in_ready;

  dlpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dlpr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (in_i.func),
    .sec_of_day_i   (in_i.sec_of_day),
    .milli_of_sec_i (in_i.milli_of_sec),
    .new_time_i     (in_i.new_time),
    .new_level_i    (in_i.new_level),
    .remove_pos_i   (in_i.remove_pos),
    .test_level_i   (in_i.test_level),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .pwm_out_o      (out_o.pwm_out),
    .write_needed_o (out_o.write_needed),
    .goal_level_o   (out_o.goal_level),
    .op_ok_o        (out_o.op_ok),
    .entry_count_o  (out_o.entry_count)
  );

endmodule

// File: rtl/dlpr_sva.sv
// Port-level checks for the daily light profile ramp, bound to the top level.
module dlpr_sva import dlpr_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [PWM_W-1:0]     pwm_out_i,
  input logic                 write_needed_i,
  input logic [PWM_W-1:0]     goal_level_i,
  input logic                 op_ok_i,
  input logic [CNT_OUT_W-1:0] entry_count_i
);

  // one item at a time: busy right after a transfer
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready stayed high after an input transfer");

  // a refused add or remove never reports a drive change
  a_fail_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !op_ok_i |-> !write_needed_i)
    else $error("failed edit flagged a PWM write");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pwm_out_i) &&
      $stable(goal_level_i) && $stable(write_needed_i) && $stable(op_ok_i) &&
      $stable(entry_count_i))
    else $error("result changed while stalled");

endmodule

bind daily_light_profile_ramp dlpr_sva u_dlpr_sva (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .pwm_out_i      (out_o.pwm_out),
  .write_needed_i (out_o.write_needed),
  .goal_level_i   (out_o.goal_level),
  .op_ok_i        (out_o.op_ok),
  .entry_count_i  (out_o.entry_count)
);

// File: tb/sv/tb.sv
// Self-checking testbench for the daily light profile ramp.
`timescale 1ns / 1ps

module tb;
  import dlpr_pkg::*;

  typedef struct packed {
    logic [1:0]       func;
    logic [SEC_W-1:0] sec_of_day;
    logic [MS_W-1:0]  milli_of_sec;
    logic [SEC_W-1:0] new_time;
    logic [LVL_W-1:0] new_level;
    logic [POS_W-1:0] remove_pos;
    logic [LVL_W-1:0] test_level;
  } item_t;

  typedef struct packed {
    logic [PWM_W-1:0]     pwm_out;
    logic                 write_needed;
    logic [PWM_W-1:0]     goal_level;
    logic                 op_ok;
    logic [CNT_OUT_W-1:0] entry_count;
  } result_t;

  localparam int NENT = 32;
  localparam longint DAY = 86400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  dlpr_in_if in_ch();
  dlpr_out_if out_ch();

  daily_light_profile_ramp DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  initial forever #6 clk_i = ~clk_i;

  // model state
  longint tbl_time[NENT];
  longint tbl_lvl[NENT];
  int     n_filled;
  longint drive, goal_r;
  bit     test_on;
  longint test_pct, test_sec;
  longint full_scale, step_sz;

  item_t   pending_items[$];
  result_t expected_results[$];
  int      send_idle_pct, recv_idle_pct;
  int      mismatches;
  longint  cycles;
  bit      done;

  function automatic longint ramp_target(longint now, longint ms);
    longint lt, ct, lv, cv, dt, dv, d, num, g;
    bit found;
    found = 0;
    lt = 0; ct = 0; lv = 0; cv = 0;
    if (n_filled == 1) begin
      lt = 0; ct = DAY; lv = tbl_lvl[0]; cv = tbl_lvl[0];
    end else begin
      for (int i = 0; i < n_filled; i++) begin
        if (!found && tbl_time[i] > now) begin
          ct = tbl_time[i]; cv = tbl_lvl[i];
          if (i == 0) begin
            lt = tbl_time[n_filled-1] - DAY; lv = tbl_lvl[n_filled-1];
          end else begin
            lt = tbl_time[i-1]; lv = tbl_lvl[i-1];
          end
          found = 1;
        end
      end
      if (!found) begin
        ct = tbl_time[0] + DAY; cv = tbl_lvl[0];
        lt = tbl_time[n_filled-1]; lv = tbl_lvl[n_filled-1];
      end
    end
    dt = ct - lt;
    dv = cv - lv;
    if (dt <= 0) begin
      d = 1; num = cv;
    end else begin
      d = dt * 1000;
      num = lv * d + dv * ((now - lt) * 1000 + ms);
      if (dv > 0) begin
        if (num > cv * d) num = cv * d;
      end else if (num < cv * d) num = cv * d;
    end
    if (num <= 0) return 0;
    g = (full_scale * num) / (d * 100);
    return (g > 65535) ? 65535 : g;
  endfunction

  function automatic longint key_of(longint t);
    return (t >= DAY) ? t - DAY : t;
  endfunction

  function automatic result_t apply_item(item_t it);
    result_t r;
    longint g, v, now, nt, pos;
    bit ok, wr;
    ok = 1; wr = 0;
    now = it.sec_of_day;
    case (dlpr_func_e'(it.func))
      FN_TICK: begin
        if (n_filled == 0) begin
          wr = drive != 0; drive = 0; goal_r = 0;
        end else begin
          g = ramp_target(now, it.milli_of_sec);
          if (test_on) begin
            g = (full_scale * test_pct) / 100;
            if (test_sec < now - 60 || test_sec > now) test_on = 0;
          end
          goal_r = g;
          v = drive;
          if (g != v) begin
            wr = 1;
            if (g > v) begin
              v += step_sz;
              if (g > v + 100) v += step_sz;
              if (v > g) v = g;
            end else begin
              v -= step_sz;
              if (g < v - 100) v -= step_sz;
              if (v < g) v = g;
            end
            drive = v;
          end
        end
      end
      FN_ADD: begin
        if (n_filled >= NENT) ok = 0;
        else begin
          nt = it.new_time;
          pos = n_filled;
          for (int i = n_filled - 1; i >= 0; i--)
            if (key_of(nt) < key_of(tbl_time[i])) pos = i;
          for (int i = n_filled; i > pos; i--) begin
            tbl_time[i] = tbl_time[i-1]; tbl_lvl[i] = tbl_lvl[i-1];
          end
          tbl_time[pos] = nt;
          tbl_lvl[pos] = (it.new_level > 100) ? 100 : it.new_level;
          n_filled++;
        end
      end
      FN_REMOVE: begin
        if (it.remove_pos >= n_filled) ok = 0;
        else begin
          for (int i = it.remove_pos; i + 1 < n_filled; i++) begin
            tbl_time[i] = tbl_time[i+1]; tbl_lvl[i] = tbl_lvl[i+1];
          end
          n_filled--;
        end
      end
      default: begin
        test_on = 1;
        test_pct = (it.test_level > 100) ? 100 : it.test_level;
        test_sec = it.sec_of_day;
      end
    endcase
    r.pwm_out = drive[15:0];
    r.write_needed = wr;
    r.goal_level = goal_r[15:0];
    r.op_ok = ok;
    r.entry_count = n_filled[5:0];
    return r;
  endfunction

  function automatic item_t rand_item(dlpr_func_e f);
    item_t it;
    it.func = f;
    it.sec_of_day = ($urandom_range(0, 19) == 0) ? SEC_W'($urandom)
                                                  : SEC_W'($urandom_range(0, 86399));
    it.milli_of_sec = ($urandom_range(0, 19) == 0) ? MS_W'($urandom)
                                                    : MS_W'($urandom_range(0, 999));
    it.new_time = ($urandom_range(0, 9) == 0) ? SEC_W'($urandom)
                                               : SEC_W'($urandom_range(0, 86400));
    it.new_level = ($urandom_range(0, 9) == 0) ? LVL_W'($urandom)
                                                : LVL_W'($urandom_range(0, 100));
    it.remove_pos = POS_W'($urandom);
    it.test_level = ($urandom_range(0, 9) == 0) ? LVL_W'($urandom)
                                                 : LVL_W'($urandom_range(0, 100));
    return it;
  endfunction

  task automatic push_item(item_t it);
    pending_items.push_back(it);
    expected_results.push_back(apply_item(it));
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(dlpr_reg_e idx, longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FULL_SCALE) full_scale = val & 16'hFFFF;
    else step_sz = val & 12'hFFF;
  endtask

  task automatic random_phase(int count);
    item_t it;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (n_filled < 3 && r < 50 || r < 12) it = rand_item(FN_ADD);
      else if (r < 20) begin
        it = rand_item(FN_REMOVE);
        if ($urandom_range(0, 3) != 0 && n_filled > 0)
          it.remove_pos = POS_W'($urandom_range(0, n_filled - 1));
      end else if (r < 24) it = rand_item(FN_TEST);
      else it = rand_item(FN_TICK);
      push_item(it);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      {in_ch.func, in_ch.sec_of_day, in_ch.milli_of_sec, in_ch.new_time,
       in_ch.new_level, in_ch.remove_pos, in_ch.test_level} <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) void'(pending_items.pop_front());
      if ((!in_ch.valid || in_ch.ready) ) begin
        if (pending_items.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
            !(in_ch.valid && in_ch.ready && pending_items.size() == 0) &&
            $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          {in_ch.func, in_ch.sec_of_day, in_ch.milli_of_sec, in_ch.new_time,
           in_ch.new_level, in_ch.remove_pos, in_ch.test_level} <= pending_items[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.pwm_out, out_ch.write_needed, out_ch.goal_level, out_ch.op_ok,
               out_ch.entry_count};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp pwm %0d wr %0d goal %0d ok %0d cnt %0d / got pwm %0d wr %0d goal %0d ok %0d cnt %0d",
                       want.pwm_out, want.write_needed, want.goal_level, want.op_ok,
                       want.entry_count, got.pwm_out, got.write_needed, got.goal_level,
                       got.op_ok, got.entry_count);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000 && !done) begin
      $display("FAIL daily_light_profile_ramp");
      $finish;
    end
  end

  initial begin
    item_t it;
    cycles = 0; done = 0; mismatches = 0;
    n_filled = 0; drive = 0; goal_r = 0; test_on = 0; test_pct = 0; test_sec = 0;
    full_scale = 4095; step_sz = 1;
    send_idle_pct = 10; recv_idle_pct = 60;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty tick, extremes, overfull, bad remove, test mode
    it = '0; push_item(it);
    it = rand_item(FN_REMOVE); it.remove_pos = 0; push_item(it);
    it = rand_item(FN_ADD); it.new_time = 3600; it.new_level = 127; push_item(it);
    it = rand_item(FN_TICK); it.sec_of_day = 0; it.milli_of_sec = 0; push_item(it);
    it = rand_item(FN_ADD); it.new_time = 86400; it.new_level = 0; push_item(it);
    it = rand_item(FN_ADD); it.new_time = 43200; it.new_level = 100; push_item(it);
    it = rand_item(FN_ADD); it.new_time = 43200; it.new_level = 7; push_item(it);
    it = rand_item(FN_ADD); it.new_time = 131071; it.new_level = 50; push_item(it);
    it = rand_item(FN_TICK); it.sec_of_day = 131071; it.milli_of_sec = 1023; push_item(it);
    it = rand_item(FN_TICK); it.sec_of_day = 86399; it.milli_of_sec = 999; push_item(it);
    it = rand_item(FN_TICK); it.sec_of_day = 43200; it.milli_of_sec = 500; push_item(it);
    it = rand_item(FN_TEST); it.sec_of_day = 1000; it.test_level = 127; push_item(it);
    it = rand_item(FN_TICK); it.sec_of_day = 1030; push_item(it);
    it = rand_item(FN_TICK); it.sec_of_day = 1061; push_item(it);
    it = rand_item(FN_REMOVE); it.remove_pos = 31; push_item(it);
    it = rand_item(FN_REMOVE); it.remove_pos = 4; push_item(it);
    for (int k = 0; k < 30; k++) begin
      it = rand_item(FN_ADD); push_item(it);
    end
    it = rand_item(FN_TICK); push_item(it);
    wait_drained();

    write_reg(REG_FULL_SCALE, 65535);
    write_reg(REG_SLEW_STEP, 4095);
    random_phase(400);
    wait_drained();

    send_idle_pct = 60; recv_idle_pct = 10;
    write_reg(REG_FULL_SCALE, 1);
    write_reg(REG_SLEW_STEP, 1);
    random_phase(400);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_FULL_SCALE, $urandom_range(1, 65535));
    write_reg(REG_SLEW_STEP, $urandom_range(1, 300));
    random_phase(450);
    wait_drained();
    write_reg(REG_FULL_SCALE, 4095);
    write_reg(REG_SLEW_STEP, 37);
    random_phase(450);
    wait_drained();

    done = 1;
    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASS daily_light_profile_ramp");
    else
      $display("FAIL daily_light_profile_ramp");
    $finish;
  end
endmodule
